### rtl/sari_pkg.sv
// Package for the six-axis servo ramp interpolator.
// Widths, codes and default parameter values; no dependencies.
package sari_pkg;

    localparam int NUM_CH        = 6;
    localparam int PULSE_W       = 15;
    localparam int STEP_NUM_W    = 7;
    localparam int STEPS_DEFAULT = 50;
    localparam int STEPS_MAX     = 64;
    // reciprocal multiplier width, enough for every ramp length up to STEPS_MAX
    localparam int RECIP_W       = PULSE_W + 2;
    localparam int PROD_W        = PULSE_W + RECIP_W;

    localparam logic CMD_RAMP   = 1'b0;
    localparam logic CMD_DIRECT = 1'b1;

    typedef logic [PULSE_W-1:0]        pulse_t;
    typedef logic signed [PULSE_W:0]   diff_t;
    typedef logic [STEP_NUM_W-1:0]     step_num_t;
    typedef logic [PROD_W-1:0]         prod_t;

endpackage

### rtl/sari_in_if.sv
// Command channel of the servo ramp interpolator: valid/ready plus one command word.
// Depends on sari_pkg.
interface sari_in_if
    import sari_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   command;
    pulse_t target_0;
    pulse_t target_1;
    pulse_t target_2;
    pulse_t target_3;
    pulse_t target_4;
    pulse_t target_5;

    modport source
    (
        output valid, command, target_0, target_1, target_2, target_3, target_4, target_5,
        input  ready
    );

    modport sink
    (
        input  valid, command, target_0, target_1, target_2, target_3, target_4, target_5,
        output ready
    );
endinterface

### rtl/sari_out_if.sv
// Result channel of the servo ramp interpolator: valid/ready plus one compare word.
// Depends on sari_pkg.
interface sari_out_if
    import sari_pkg::*;
();
    logic      valid;
    logic      ready;
    pulse_t    compare_0;
    pulse_t    compare_1;
    pulse_t    compare_2;
    pulse_t    compare_3;
    pulse_t    compare_4;
    pulse_t    compare_5;
    step_num_t step_number;
    logic      last;

    modport source
    (
        output valid, compare_0, compare_1, compare_2, compare_3, compare_4, compare_5,
               step_number, last,
        input  ready
    );

    modport sink
    (
        input  valid, compare_0, compare_1, compare_2, compare_3, compare_4, compare_5,
               step_number, last,
        output ready
    );
endinterface

### rtl/six_axis_servo_ramp_interpolator.sv
// Six-axis servo ramp interpolator top level.
// Depends on sari_pkg, sari_in_if, sari_out_if.
//
// Each command word carries six target pulse widths. A direct command yields one result
// word with the targets (step_number 0, last 1). A ramp command yields STEPS words, with
// STEPS clamped to 1..64. Word i holds current + i * step per channel, where step is
// (target - current) / STEPS truncated toward zero, and the final word is flagged with
// last. After either command the targets become the current values. Pipeline: difference,
// reciprocal multiply, then a ramp accumulator feeding the output register, each stage
// registered. The accumulator produces one word per cycle while the output register is
// free, so a ramp command holds it until its STEPS words are out and a direct command
// until its one word is out. Command words are taken every cycle while the pipeline
// ahead of the accumulator has room.
module six_axis_servo_ramp_interpolator
    import sari_pkg::*;
#(
    parameter int STEPS = STEPS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    sari_in_if.sink     request,
    sari_out_if.source  result
);

    // ramp length actually used
    localparam int RAMP_LEN   = (STEPS < 1) ? 1 : ((STEPS > STEPS_MAX) ? STEPS_MAX : STEPS);
    // exact divide by RAMP_LEN for 15-bit magnitudes: q = (m * RECIP) >> STEP_SHIFT
    localparam int STEP_SHIFT = PULSE_W + $clog2(RAMP_LEN);
    localparam int RECIP      = ((1 << STEP_SHIFT) + RAMP_LEN - 1) / RAMP_LEN;
    localparam logic [RECIP_W-1:0] RECIP_K   = RECIP_W'(RECIP);
    localparam step_num_t          LAST_STEP = STEP_NUM_W'(RAMP_LEN);

    pulse_t tgt_in [NUM_CH];
    pulse_t cur_reg [NUM_CH];

    // stage 1: difference magnitude and sign
    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    pulse_t            s1_tgt_reg  [NUM_CH];
    pulse_t            s1_base_reg [NUM_CH];
    pulse_t            s1_mag_reg  [NUM_CH];
    logic [NUM_CH-1:0] s1_neg_reg;

    // stage 2: reciprocal product
    logic              s2_valid_reg;
    logic              s2_cmd_reg;
    pulse_t            s2_tgt_reg  [NUM_CH];
    pulse_t            s2_base_reg [NUM_CH];
    prod_t             s2_prod_reg [NUM_CH];
    logic [NUM_CH-1:0] s2_neg_reg;

    // stage 3: ramp accumulator
    logic              s3_valid_reg;
    logic              s3_cmd_reg;
    pulse_t            s3_tgt_reg  [NUM_CH];
    pulse_t            s3_acc_reg  [NUM_CH];
    diff_t             s3_step_reg [NUM_CH];
    step_num_t         s3_cnt_reg;

    // output register
    logic              out_valid_reg;
    pulse_t            out_cmp_reg [NUM_CH];
    step_num_t         out_step_reg;
    logic              out_last_reg;

    diff_t             diff      [NUM_CH];
    logic [NUM_CH-1:0] diff_neg;
    pulse_t            diff_mag  [NUM_CH];
    diff_t             step_next [NUM_CH];
    pulse_t            acc_next  [NUM_CH];
    pulse_t            quot      [NUM_CH];

    logic accept;
    logic out_free;
    logic emit3;
    logic fin3;
    logic s3_free;
    logic adv2;
    logic s2_free;
    logic adv1;
    logic s1_free;

    assign tgt_in[0] = request.target_0;
    assign tgt_in[1] = request.target_1;
    assign tgt_in[2] = request.target_2;
    assign tgt_in[3] = request.target_3;
    assign tgt_in[4] = request.target_4;
    assign tgt_in[5] = request.target_5;

    // flow control, back to front
    assign out_free = !out_valid_reg || result.ready;
    assign emit3    = s3_valid_reg && out_free;
    assign fin3     = (s3_cmd_reg == CMD_DIRECT) || (s3_cnt_reg == LAST_STEP);
    assign s3_free  = !s3_valid_reg || (emit3 && fin3);
    assign adv2     = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || adv2;
    assign adv1     = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || adv1;
    assign accept   = request.valid && s1_free;

    assign request.ready = s1_free;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            diff[ch]     = diff_t'({1'b0, tgt_in[ch]}) - diff_t'({1'b0, cur_reg[ch]});
            diff_neg[ch] = diff[ch][PULSE_W];
            diff_mag[ch] = diff_neg[ch] ? PULSE_W'(-diff[ch]) : diff[ch][PULSE_W-1:0];
            quot[ch]     = PULSE_W'(s2_prod_reg[ch] >> STEP_SHIFT);
            step_next[ch] = s2_neg_reg[ch] ? -diff_t'({1'b0, quot[ch]})
                                           :  diff_t'({1'b0, quot[ch]});
            acc_next[ch] = PULSE_W'(diff_t'({1'b0, s3_acc_reg[ch]}) + s3_step_reg[ch]);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            s3_cnt_reg    <= '0;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                cur_reg[ch] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    cur_reg[ch] <= tgt_in[ch];
                end
            end
            if (s1_free)
            begin
                s1_valid_reg <= request.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
                if (s2_valid_reg)
                begin
                    s3_cnt_reg <= step_num_t'(1);
                end
            end
            else if (emit3)
            begin
                s3_cnt_reg <= s3_cnt_reg + step_num_t'(1);
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= request.command;
            s1_neg_reg <= diff_neg;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                s1_tgt_reg[ch]  <= tgt_in[ch];
                s1_base_reg[ch] <= cur_reg[ch];
                s1_mag_reg[ch]  <= diff_mag[ch];
            end
        end
        if (adv1)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            s2_neg_reg <= s1_neg_reg;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                s2_tgt_reg[ch]  <= s1_tgt_reg[ch];
                s2_base_reg[ch] <= s1_base_reg[ch];
                s2_prod_reg[ch] <= PROD_W'(s1_mag_reg[ch]) * PROD_W'(RECIP_K);
            end
        end
        if (adv2)
        begin
            s3_cmd_reg <= s2_cmd_reg;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                s3_tgt_reg[ch]  <= s2_tgt_reg[ch];
                s3_acc_reg[ch]  <= s2_base_reg[ch];
                s3_step_reg[ch] <= step_next[ch];
            end
        end
        else if (emit3)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                s3_acc_reg[ch] <= acc_next[ch];
            end
        end
        if (emit3)
        begin
            out_last_reg <= fin3;
            if (s3_cmd_reg == CMD_DIRECT)
            begin
                out_step_reg <= '0;
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    out_cmp_reg[ch] <= s3_tgt_reg[ch];
                end
            end
            else
            begin
                out_step_reg <= s3_cnt_reg;
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    out_cmp_reg[ch] <= acc_next[ch];
                end
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.compare_0   = out_cmp_reg[0];
    assign result.compare_1   = out_cmp_reg[1];
    assign result.compare_2   = out_cmp_reg[2];
    assign result.compare_3   = out_cmp_reg[3];
    assign result.compare_4   = out_cmp_reg[4];
    assign result.compare_5   = out_cmp_reg[5];
    assign result.step_number = out_step_reg;
    assign result.last        = out_last_reg;

endmodule

### rtl/sari_checker.sv
// Port-level checks for the servo ramp interpolator, bound to the top level.
// Depends on sari_pkg.
module sari_checker
    import sari_pkg::*;
#(
    parameter int STEPS = STEPS_DEFAULT
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input step_num_t out_step_number,
    input logic      out_last
);

    localparam int        RAMP_LEN  = (STEPS < 1) ? 1
                                    : ((STEPS > STEPS_MAX) ? STEPS_MAX : STEPS);
    localparam step_num_t LAST_STEP = STEP_NUM_W'(RAMP_LEN);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_step_number) && $stable(out_last))
        else $error("result word changed while stalled");

    // direct words are always single and final
    a_direct_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_step_number == '0) |-> out_last)
        else $error("direct word without last");

    // ramp index stays in range and the final ramp word is at STEPS
    a_ramp_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_step_number != '0) |->
            (out_step_number <= LAST_STEP) && (out_last == (out_step_number == LAST_STEP)))
        else $error("ramp index out of range or last misplaced");

    // a word taken without last is followed by the next ramp index
    a_ramp_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last ##1 out_valid |->
            out_step_number == step_num_t'($past(out_step_number) + step_num_t'(1)))
        else $error("ramp index skipped");

endmodule

bind six_axis_servo_ramp_interpolator sari_checker #(.STEPS(STEPS)) u_sari_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_step_number (result.step_number),
    .out_last        (result.last)
);

### dv/testbench.sv
// Testbench for six_axis_servo_ramp_interpolator: directed table then random commands,
// with result words checked against an in-bench ramp predictor.
// Depends on sari_pkg, sari_in_if, sari_out_if and the RTL top level.
`timescale 1ns / 100ps

module testbench;
    import sari_pkg::*;

    localparam int RAMP_STEPS  = STEPS_DEFAULT;
    localparam int RAMP_LEN    = (RAMP_STEPS < 1) ? 1
                               : ((RAMP_STEPS > STEPS_MAX) ? STEPS_MAX : RAMP_STEPS);
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 70;
    localparam int PRINT_CAP    = 50;

    // channel 5 in the top slice, channel 0 in the bottom one
    typedef logic [NUM_CH-1:0][PULSE_W-1:0] pulse_set_t;

    typedef struct packed {
        pulse_set_t cmp;
        step_num_t  step;
        logic       last;
    } servo_word_t;

    typedef struct packed {
        logic       cmd;
        pulse_set_t tgt;
        logic       typed;
        pulse_set_t exp;
    } command_row_t;

    localparam int NUM_ROWS = 17;
    localparam pulse_set_t ALL_ZERO = {6{15'd0}};
    localparam pulse_set_t ALL_MAX  = {6{15'd32767}};
    localparam pulse_set_t ALL_TOP  = {6{15'd19999}};
    localparam pulse_set_t ALT_A    = {3{15'h5555, 15'h2AAA}};
    localparam pulse_set_t ALT_B    = {3{15'h2AAA, 15'h5555}};
    localparam pulse_set_t SMALL    = {15'd49, 15'd1, 15'd50, 15'd51, 15'd0, 15'd100};
    localparam pulse_set_t MIXED_A  = {15'd0, 15'd19999, 15'd49, 15'd19950, 15'd10000, 15'd20000};
    localparam pulse_set_t MIXED_B  = {15'd12345, 15'd1, 15'd32767, 15'd0, 15'd19999, 15'd7};

    command_row_t directed_rows [NUM_ROWS] = '{
        '{CMD_RAMP,   ALL_ZERO, 1'b1, ALL_ZERO},   // ramp onto the reset position
        '{CMD_DIRECT, ALL_MAX,  1'b1, ALL_MAX},    // above 19999, taken as given
        '{CMD_RAMP,   ALL_ZERO, 1'b0, ALL_ZERO},   // full swing down
        '{CMD_RAMP,   ALL_MAX,  1'b0, ALL_ZERO},   // full swing up
        '{CMD_RAMP,   ALL_MAX,  1'b1, ALL_MAX},
        '{CMD_DIRECT, ALL_ZERO, 1'b1, ALL_ZERO},
        '{CMD_RAMP,   SMALL,    1'b0, ALL_ZERO},   // diffs below STEPS truncate to zero step
        '{CMD_RAMP,   ALL_ZERO, 1'b0, ALL_ZERO},
        '{CMD_DIRECT, ALL_TOP,  1'b1, ALL_TOP},
        '{CMD_RAMP,   MIXED_A,  1'b0, ALL_ZERO},
        '{CMD_RAMP,   ALT_A,    1'b0, ALL_ZERO},
        '{CMD_RAMP,   ALT_B,    1'b0, ALL_ZERO},
        '{CMD_DIRECT, ALT_A,    1'b1, ALT_A},
        '{CMD_DIRECT, ALT_B,    1'b1, ALT_B},
        '{CMD_RAMP,   MIXED_B,  1'b0, ALL_ZERO},
        '{CMD_RAMP,   MIXED_B,  1'b1, MIXED_B},
        '{CMD_DIRECT, ALL_ZERO, 1'b1, ALL_ZERO}
    };

    logic clk;
    logic rst_n;

    sari_in_if  request_if ();
    sari_out_if result_if ();

    six_axis_servo_ramp_interpolator #(
        .STEPS (RAMP_STEPS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_if),
        .result  (result_if)
    );

    servo_word_t pending_words [$];
    pulse_set_t  servo_pos;
    int          cycle_count;
    int          error_count;
    int          words_checked;
    int          ramps_sent;
    int          directs_sent;
    int          sender_idle_pct;
    int          recv_stall_pct;
    int          hold_requests;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(string what, int want, int got);
        // keep the log short when the design is badly broken
        if (error_count < PRINT_CAP)
        begin
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
        end
        error_count++;
    endtask

    // Ramp predictor: queues the words a command yields and moves the position on.
    function automatic void predict_command(logic cmd, pulse_set_t tgt);
        servo_word_t w;
        int          step_size [NUM_CH];
        if (cmd == CMD_DIRECT)
        begin
            w.cmp  = tgt;
            w.step = '0;
            w.last = 1'b1;
            pending_words.push_back(w);
        end
        else
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                step_size[ch] = (int'(tgt[ch]) - int'(servo_pos[ch])) / RAMP_LEN;
            end
            for (int i = 1; i <= RAMP_LEN; i++)
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    w.cmp[ch] = pulse_t'(int'(servo_pos[ch]) + i * step_size[ch]);
                end
                w.step = step_num_t'(i);
                w.last = (i == RAMP_LEN);
                pending_words.push_back(w);
            end
        end
        servo_pos = tgt;
    endfunction

    // Rows whose words repeat one known set of values.
    function automatic void expect_fixed(command_row_t row);
        servo_word_t w;
        int          count;
        count = (row.cmd == CMD_DIRECT) ? 1 : RAMP_LEN;
        for (int i = 1; i <= count; i++)
        begin
            w.cmp  = row.exp;
            w.step = (row.cmd == CMD_DIRECT) ? step_num_t'(0) : step_num_t'(i);
            w.last = (i == count);
            pending_words.push_back(w);
        end
        servo_pos = row.tgt;
    endfunction

    function automatic pulse_t pick_target(pulse_t cur);
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(19999);
            4:          v = $urandom_range(32767);
            5, 6:       v = int'(cur) + int'($urandom_range(240)) - 120;
            7:          v = int'(cur);
            8:          v = $urandom_range(1) ? 32767 : 0;
            default:    v = $urandom_range(1) ? 19999 : 1;
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 32767)
        begin
            v = 32767;
        end
        return pulse_t'(v);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_command(logic cmd, pulse_set_t tgt);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            request_if.valid <= 1'b0;
            @(negedge clk);
        end
        request_if.valid    <= 1'b1;
        request_if.command  <= cmd;
        request_if.target_0 <= tgt[0];
        request_if.target_1 <= tgt[1];
        request_if.target_2 <= tgt[2];
        request_if.target_3 <= tgt[3];
        request_if.target_4 <= tgt[4];
        request_if.target_5 <= tgt[5];
        do
        begin
            @(posedge clk);
        end
        while (!request_if.ready);
        if (cmd == CMD_DIRECT)
        begin
            directs_sent++;
        end
        else
        begin
            ramps_sent++;
        end
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        request_if.valid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Result side: random stalls, plus a long hold when one is requested.
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left       = 0;
        holds_done      = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        servo_word_t want;
        servo_word_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.cmp  = {result_if.compare_5, result_if.compare_4, result_if.compare_3,
                        result_if.compare_2, result_if.compare_1, result_if.compare_0};
            got.step = result_if.step_number;
            got.last = result_if.last;
            if (pending_words.size() == 0)
            begin
                report_mismatch("word with nothing pending, step_number", -1, int'(got.step));
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    if (got.cmp[ch] !== want.cmp[ch])
                    begin
                        report_mismatch($sformatf("compare_%0d", ch),
                                        int'(want.cmp[ch]), int'(got.cmp[ch]));
                    end
                end
                if (got.step !== want.step)
                begin
                    report_mismatch("step_number", int'(want.step), int'(got.step));
                end
                if (got.last !== want.last)
                begin
                    report_mismatch("last", int'(want.last), int'(got.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycle_count, pending_words.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        pulse_set_t tgt;
        logic       cmd;
        cycle_count         = 0;
        error_count         = 0;
        words_checked       = 0;
        ramps_sent          = 0;
        directs_sent        = 0;
        sender_idle_pct     = 0;
        recv_stall_pct      = 0;
        hold_requests       = 0;
        servo_pos           = '0;
        rst_n               = 1'b0;
        request_if.valid    = 1'b0;
        request_if.command  = CMD_RAMP;
        request_if.target_0 = '0;
        request_if.target_1 = '0;
        request_if.target_2 = '0;
        request_if.target_3 = '0;
        request_if.target_4 = '0;
        request_if.target_5 = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            send_command(directed_rows[r].cmd, directed_rows[r].tgt);
            if (directed_rows[r].typed)
            begin
                expect_fixed(directed_rows[r]);
            end
            else
            begin
                predict_command(directed_rows[r].cmd, directed_rows[r].tgt);
            end
        end
        wait_for_drain();

        // phases: no idling (with a long result hold), sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1) ? 82 : ((phase == 3) ? 29 : 0);
            recv_stall_pct  = (phase == 2) ? 82 : ((phase == 3) ? 29 : 0);
            if (phase == 0)
            begin
                hold_requests++;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                cmd = ($urandom_range(99) < 40) ? CMD_DIRECT : CMD_RAMP;
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    tgt[ch] = pick_target(servo_pos[ch]);
                end
                send_command(cmd, tgt);
                predict_command(cmd, tgt);
            end
            wait_for_drain();
        end

        $display("covered %0d commands (%0d ramps of %0d words, %0d direct sets), %0d words checked",
                 ramps_sent + directs_sent, ramps_sent, RAMP_LEN, directs_sent, words_checked);
        $display("idling phases: none with a %0d-cycle result hold, sender, receiver, both",
                 HOLD_CYCLES);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/sari_pkg.sv
rtl/sari_in_if.sv
rtl/sari_out_if.sv
rtl/six_axis_servo_ramp_interpolator.sv
rtl/sari_checker.sv
dv/testbench.sv
